>>> rtl/pts_pkg.sv
// Shared types, constants and helpers of the priority task scheduler.
package pts_pkg;

  localparam int TASKS    = 32;
  localparam int LEVELS   = 8;
  localparam int TASK_W   = 5;
  localparam int PTR_W    = TASK_W + 1;
  localparam int LVL_W    = 3;
  localparam int TICK_W   = 64;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(TASKS);

  localparam logic [1:0] ST_UNUSED  = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  localparam logic [2:0] EV_TICK    = 3'd0;
  localparam logic [2:0] EV_ADMIT   = 3'd1;
  localparam logic [2:0] EV_BLOCK   = 3'd2;
  localparam logic [2:0] EV_UNBLOCK = 3'd3;
  localparam logic [2:0] EV_YIELD   = 3'd4;
  localparam logic [2:0] EV_SLEEP   = 3'd5;

  localparam logic [7:0] SLICE_BASE_RESET = 8'd10;

  typedef struct packed {
    logic [TICK_W-1:0] sum;
    logic              le;
  } alu_res_t;

  // Slice given on every queueing: base plus LEVELS minus the level, capped at 255.
  function automatic logic [7:0] fresh_slice(input logic [7:0] base, input logic [LVL_W-1:0] lv);
    logic [9:0] v;
    v = {2'b00, base} + 10'(LEVELS) - {{(10-LVL_W){1'b0}}, lv};
    return (v > 10'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

>>> rtl/priority_task_scheduler_unit.sv
// Priority task scheduler: multilevel ready queues, sorted sleep list, sequencer.
// A refused request passes only through decode and done; a tick wakes due sleepers one per
// pass and a sleep walks the sleep list one entry at a time, so list walks set the length.
// Throughput: one transaction at a time; s_tready is high only while the sequencer is idle.
// Reset (rst, synchronous, active high) clears task states, ready bitmap, sleep list,
// tick counter and running task, and loads slice_base with 10; no clearing pass is needed.
module priority_task_scheduler_unit
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // task_id[4:0], priority_req[9:5], sleep_ticks[41:10], zero
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // running_task[4:0], cpu_idle[5], switched[6], ignored[7],
                                 // ready_levels[15:8], zero[39:16], slice_left[47:40]
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_ENQ       = 4'd2;
  localparam logic [3:0] S_WAKE      = 4'd3;
  localparam logic [3:0] S_SLICE     = 4'd4;
  localparam logic [3:0] S_DISPATCH  = 4'd5;
  localparam logic [3:0] S_TAKE      = 4'd6;
  localparam logic [3:0] S_DEQ_WALK  = 4'd7;
  localparam logic [3:0] S_SREM_WALK = 4'd8;
  localparam logic [3:0] S_SINS_WALK = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state;
  logic [3:0] ret_state;

  // Task tables. Link pointers, queue ends and per-task payload are only read after
  // being written, so they carry no reset.
  logic [1:0]        task_status [TASKS];
  logic [LVL_W-1:0]  task_level  [TASKS];
  logic [7:0]        task_slice  [TASKS];
  logic [TICK_W-1:0] wake_tick   [TASKS];
  logic [PTR_W-1:0]  link_next   [TASKS];
  logic [PTR_W-1:0]  queue_head  [LEVELS];
  logic [PTR_W-1:0]  queue_tail  [LEVELS];
  logic [LEVELS-1:0] level_bitmap;
  logic [PTR_W-1:0]  sleep_head;
  logic [TICK_W-1:0] tick_count;
  logic [PTR_W-1:0]  current_task;
  logic [7:0]        slice_base;

  // Latched transaction and working registers of the sequencer.
  logic [2:0]        ev_kind;
  logic [TASK_W-1:0] ev_id;
  logic [4:0]        ev_prio;
  logic [31:0]       ev_ticks;
  logic [PTR_W-1:0]  before_task;
  logic              ign;
  logic [PTR_W-1:0]  enq_task;
  logic [PTR_W-1:0]  walk_prev;
  logic [PTR_W-1:0]  walk_cur;
  logic [TICK_W-1:0] wake_key;
  logic [LVL_W-1:0]  disp_lv;
  logic [PTR_W-1:0]  disp_nxt;

  logic [TICK_W-1:0] alu_a;
  logic [TICK_W-1:0] alu_b;
  alu_res_t          alu_res;

  pts_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Operand selection for the shared adder and comparator.
  always_comb begin
    alu_a = tick_count;
    alu_b = TICK_W'(1);
    unique case (state)
      S_DECODE: begin
        alu_a = tick_count;
        alu_b = (ev_kind == EV_SLEEP) ? {32'd0, ev_ticks} : TICK_W'(1);
      end
      S_WAKE: begin
        alu_a = wake_tick[sleep_head[TASK_W-1:0]];
        alu_b = tick_count;
      end
      S_SINS_WALK: begin
        alu_a = wake_tick[walk_cur[TASK_W-1:0]];
        alu_b = wake_key;
      end
      default: begin
        alu_a = tick_count;
        alu_b = TICK_W'(1);
      end
    endcase
  end

  logic [TASK_W-1:0] cur_idx;
  logic              cur_valid;
  logic              cur_runs;
  logic [1:0]        id_status;
  logic [LVL_W-1:0]  low_lv;
  logic [LVL_W-1:0]  enq_lv;
  logic [7:0]        dec_slice;

  always_comb begin
    cur_idx   = current_task[TASK_W-1:0];
    cur_valid = !current_task[PTR_W-1];
    cur_runs  = cur_valid && (task_status[cur_idx] == ST_RUNNING);
    id_status = task_status[ev_id];
    enq_lv    = task_level[enq_task[TASK_W-1:0]];
    dec_slice = (task_slice[cur_idx] != 8'd0) ? task_slice[cur_idx] - 8'd1 : 8'd0;
    low_lv    = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_bitmap[i]) begin
        low_lv = LVL_W'(i);
      end
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret_state    <= S_DONE;
      level_bitmap <= '0;
      sleep_head   <= NIL;
      tick_count   <= '0;
      current_task <= NIL;
      slice_base   <= SLICE_BASE_RESET;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        task_status[i] <= ST_UNUSED;
      end
    end else begin
      if (cfg_wr_en) begin
        slice_base <= cfg_wr_data;
      end
      // The result register empties on a handshake unless a new result is loaded below.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ev_kind     <= s_tuser;
            ev_id       <= s_tdata[4:0];
            ev_prio     <= s_tdata[9:5];
            ev_ticks    <= s_tdata[41:10];
            before_task <= current_task;
            ign         <= 1'b0;
            state       <= S_DECODE;
          end
        end

        S_DECODE: begin
          unique case (ev_kind)
            EV_TICK: begin
              tick_count <= alu_res.sum;
              state      <= S_WAKE;
            end
            EV_ADMIT: begin
              if (id_status != ST_UNUSED) begin
                ign   <= 1'b1;
                state <= S_DONE;
              end else begin
                task_level[ev_id] <= (ev_prio >= 5'(LEVELS)) ? LVL_W'(LEVELS - 1)
                                                               : ev_prio[LVL_W-1:0];
                enq_task  <= {1'b0, ev_id};
                ret_state <= S_DONE;
                state     <= S_ENQ;
              end
            end
            EV_BLOCK: begin
              if (id_status == ST_UNUSED || id_status == ST_BLOCKED) begin
                ign   <= 1'b1;
                state <= S_DONE;
              end else begin
                task_status[ev_id] <= ST_BLOCKED;
                if (id_status == ST_READY) begin
                  walk_prev <= NIL;
                  walk_cur  <= queue_head[task_level[ev_id]];
                  state     <= S_DEQ_WALK;
                end else if ({1'b0, ev_id} == current_task) begin
                  state <= S_DISPATCH;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            EV_UNBLOCK: begin
              if (id_status != ST_BLOCKED) begin
                ign   <= 1'b1;
                state <= S_DONE;
              end else begin
                walk_prev <= NIL;
                walk_cur  <= sleep_head;
                state     <= S_SREM_WALK;
              end
            end
            EV_YIELD: begin
              if (cur_valid) begin
                task_slice[cur_idx] <= 8'd0;
              end
              state <= S_DISPATCH;
            end
            EV_SLEEP: begin
              if (!cur_valid) begin
                ign   <= 1'b1;
                state <= S_DONE;
              end else begin
                wake_tick[cur_idx]   <= alu_res.sum;
                wake_key             <= alu_res.sum;
                task_status[cur_idx] <= ST_BLOCKED;
                walk_prev            <= NIL;
                walk_cur             <= sleep_head;
                state                <= S_SINS_WALK;
              end
            end
            default: begin
              ign   <= 1'b1;
              state <= S_DONE;
            end
          endcase
        end

        // Append enq_task to the tail of its level with a fresh slice.
        S_ENQ: begin
          link_next[enq_task[TASK_W-1:0]] <= NIL;
          if (!level_bitmap[enq_lv]) begin
            queue_head[enq_lv]   <= enq_task;
            level_bitmap[enq_lv] <= 1'b1;
          end else begin
            link_next[queue_tail[enq_lv][TASK_W-1:0]] <= enq_task;
          end
          queue_tail[enq_lv]                <= enq_task;
          task_status[enq_task[TASK_W-1:0]] <= ST_READY;
          task_slice[enq_task[TASK_W-1:0]]  <= fresh_slice(slice_base, enq_lv);
          state                             <= ret_state;
        end

        // Wake due sleepers one per pass, then charge the running slice.
        S_WAKE: begin
          if (!sleep_head[PTR_W-1] && alu_res.le) begin
            sleep_head <= link_next[sleep_head[TASK_W-1:0]];
            enq_task   <= sleep_head;
            ret_state  <= S_WAKE;
            state      <= S_ENQ;
          end else begin
            state <= S_SLICE;
          end
        end

        S_SLICE: begin
          if (cur_valid) begin
            task_slice[cur_idx] <= dec_slice;
            state <= (dec_slice == 8'd0) ? S_DISPATCH : S_DONE;
          end else begin
            state <= S_DISPATCH;
          end
        end

        // Run the most urgent head, requeueing a running task; with none ready, keep it.
        S_DISPATCH: begin
          if (level_bitmap == '0) begin
            if (cur_runs) begin
              task_slice[cur_idx] <= fresh_slice(slice_base, task_level[cur_idx]);
            end else begin
              current_task <= NIL;
            end
            state <= S_DONE;
          end else begin
            disp_lv  <= low_lv;
            disp_nxt <= queue_head[low_lv];
            if (cur_runs) begin
              enq_task  <= current_task;
              ret_state <= S_TAKE;
              state     <= S_ENQ;
            end else begin
              state <= S_TAKE;
            end
          end
        end

        S_TAKE: begin
          queue_head[disp_lv] <= link_next[disp_nxt[TASK_W-1:0]];
          if (queue_tail[disp_lv] == disp_nxt) begin
            queue_tail[disp_lv] <= NIL;
          end
          if (link_next[disp_nxt[TASK_W-1:0]] == NIL) begin
            level_bitmap[disp_lv] <= 1'b0;
          end
          task_status[disp_nxt[TASK_W-1:0]] <= ST_RUNNING;
          current_task                      <= disp_nxt;
          state                             <= S_DONE;
        end

        // Unlink a ready task from anywhere in its queue, head included.
        S_DEQ_WALK: begin
          if (walk_cur[PTR_W-1]) begin
            state <= S_DONE;
          end else if (walk_cur == {1'b0, ev_id}) begin
            if (walk_prev[PTR_W-1]) begin
              queue_head[task_level[ev_id]] <= link_next[ev_id];
              if (link_next[ev_id] == NIL) begin
                level_bitmap[task_level[ev_id]] <= 1'b0;
              end
            end else begin
              link_next[walk_prev[TASK_W-1:0]] <= link_next[ev_id];
            end
            if (queue_tail[task_level[ev_id]] == {1'b0, ev_id}) begin
              queue_tail[task_level[ev_id]] <= walk_prev;
            end
            state <= S_DONE;
          end else begin
            walk_prev <= walk_cur;
            walk_cur  <= link_next[walk_cur[TASK_W-1:0]];
          end
        end

        // Take an unblocked task out of the sleep list if it is there, then queue it.
        S_SREM_WALK: begin
          if (walk_cur[PTR_W-1] || walk_cur == {1'b0, ev_id}) begin
            if (!walk_cur[PTR_W-1]) begin
              if (walk_prev[PTR_W-1]) begin
                sleep_head <= link_next[ev_id];
              end else begin
                link_next[walk_prev[TASK_W-1:0]] <= link_next[ev_id];
              end
            end
            enq_task  <= {1'b0, ev_id};
            ret_state <= S_DONE;
            state     <= S_ENQ;
          end else begin
            walk_prev <= walk_cur;
            walk_cur  <= link_next[walk_cur[TASK_W-1:0]];
          end
        end

        // Insert the sleeping task after every entry that wakes no later.
        S_SINS_WALK: begin
          if (!walk_cur[PTR_W-1] && alu_res.le) begin
            walk_prev <= walk_cur;
            walk_cur  <= link_next[walk_cur[TASK_W-1:0]];
          end else begin
            link_next[cur_idx] <= walk_cur;
            if (walk_prev[PTR_W-1]) begin
              sleep_head <= current_task;
            end else begin
              link_next[walk_prev[TASK_W-1:0]] <= current_task;
            end
            state <= S_DISPATCH;
          end
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata[4:0]   <= cur_valid ? cur_idx : '0;
            m_tdata[5]     <= !cur_valid;
            m_tdata[6]     <= (before_task != current_task);
            m_tdata[7]     <= ign;
            m_tdata[39:8]  <= 32'(level_bitmap);
            m_tdata[47:40] <= cur_valid ? task_slice[cur_idx] : 8'd0;
            m_tvalid       <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pts_alu.sv
// Shared 64-bit adder and less-or-equal comparator of the scheduler sequencer.
module pts_alu
  import pts_pkg::*;
(
  input  logic [TICK_W-1:0] a,
  input  logic [TICK_W-1:0] b,
  output alu_res_t          res
);

  always_comb begin
    res.sum = a + b;
    res.le  = (a <= b);
  end

endmodule
